@@ rtl/aros_pkg.sv @@
// aros_pkg: shared constants, field widths and controller/datapath structs
// for the approximate read overlap selector; no dependencies
`default_nettype none

package aros_pkg;

   localparam int READ_LEN_DEF   = 100;
   localparam int MAX_SHIFTS_DEF = 12;

   localparam int BASE_W  = 8;
   localparam int CID_W   = 12;
   localparam int CNT_W   = 7;
   localparam int VAL_W   = 8;
   localparam int IDX_W   = 13;
   localparam int LIMIT_W = 7;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd2;
   localparam logic [CNT_W-1:0]   CNT_MAX     = 7'h7F;

   localparam logic CMD_REF  = 1'b0;
   localparam logic CMD_CAND = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic idle;   // ready for an item
      logic rd;     // issue reference read for current shift
      logic cmp;    // compare and update current shift counter
      logic fin;    // publish result and update running best
   } aros_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic cand_go;     // candidate item offered
      logic last_shift;  // current shift is the final one
      logic last_item;   // latched item ends its read
      logic out_free;    // result register can take a new item
   } aros_sts_type;

endpackage

`default_nettype wire

@@ rtl/aros_if.sv @@
// aros channel interfaces: request, response and csr write channels
// depends on aros_pkg for field widths
`default_nettype none

interface aros_req_if import aros_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [BASE_W-1:0] base;
   logic [CID_W-1:0]  candidate_id;
   logic              last_base;

   modport source (output valid, cmd, base, candidate_id, last_base, input ready);
   modport sink   (input valid, cmd, base, candidate_id, last_base, output ready);
endinterface

interface aros_rsp_if import aros_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     candidate_found;
   logic signed [VAL_W-1:0]  candidate_value;
   logic signed [IDX_W-1:0]  best_index;
   logic signed [VAL_W-1:0]  best_value;

   modport source (output valid, candidate_found, candidate_value, best_index, best_value,
                   input ready);
   modport sink   (input valid, candidate_found, candidate_value, best_index, best_value,
                   output ready);
   modport mon    (input valid, ready, candidate_found, candidate_value, best_index,
                   best_value);
endinterface

interface aros_csr_if import aros_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [LIMIT_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

@@ rtl/approx_read_overlap_select.sv @@
// approx_read_overlap_select: top level, sequencer plus datapath
// depends on aros_pkg, aros_if, aros_ctrl and aros_dp
//
//   channel   dir   handshake            payload
//   req_ch    in    valid / ready        cmd, base, candidate_id, last_base
//   rsp_ch    out   valid / ready        candidate_found, candidate_value,
//                                        best_index, best_value
//   csr_ch    in    valid / ready (=1)   data (mismatch_limit, 7 bits)
//
// a reference base (cmd 0) is taken in the idle state; a candidate base walks
// S = min(MAX_SHIFTS, READ_LEN) shifts, paced by the one read port of
// the reference memory (address then compare for each shift); the last
// base of a candidate adds a publish state for the result
// reset is synchronous and active high; the reference memory is not cleared
// a stalled rsp_ch holds its item; the next candidate base is still taken
// and worked on, and only the following publish waits for the slot
`default_nettype none

module approx_read_overlap_select import aros_pkg::*; #(
   parameter int READ_LEN   = READ_LEN_DEF,
   parameter int MAX_SHIFTS = MAX_SHIFTS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   aros_req_if.sink   req_ch,
   aros_rsp_if.source rsp_ch,
   aros_csr_if.sink   csr_ch
);

   // command and status between sequencer and datapath
   aros_cmd_type cmd;
   aros_sts_type sts;

   // sequencer: idle, then address/compare per shift, then publish after a last base
   aros_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   // datapath: reference memory, mismatch counters, running best
   aros_dp #(
      .READ_LEN   (READ_LEN),
      .MAX_SHIFTS (MAX_SHIFTS)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch),
      .cmd    (cmd),
      .sts    (sts)
   );

endmodule

`default_nettype wire

@@ rtl/aros_ctrl.sv @@
// aros_ctrl: sequencer that walks the shifts for each candidate base
// depends on aros_pkg for the command and status structs
`default_nettype none

module aros_ctrl import aros_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire aros_sts_type sts,
   output aros_cmd_type      cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_ADDR = 2'd1;
   localparam logic [1:0] S_CMP  = 2'd2;
   localparam logic [1:0] S_FIN  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (sts.cand_go) state_in = S_ADDR;
         end
         S_ADDR: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            if (sts.last_shift) state_in = sts.last_item ? S_FIN : S_IDLE;
            else                state_in = S_ADDR;
         end
         S_FIN: begin
            if (sts.out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      cmd.idle = (state_ff == S_IDLE);
      cmd.rd   = (state_ff == S_ADDR);
      cmd.cmp  = (state_ff == S_CMP);
      cmd.fin  = (state_ff == S_FIN) && sts.out_free;
   end

endmodule

`default_nettype wire

@@ rtl/aros_dp.sv @@
// aros_dp: reference memory, shift mismatch counters, running best and
// result register; depends on aros_pkg and the aros channel interfaces
`default_nettype none

module aros_dp import aros_pkg::*; #(
   parameter int READ_LEN   = READ_LEN_DEF,
   parameter int MAX_SHIFTS = MAX_SHIFTS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   aros_req_if.sink          req_ch,
   aros_rsp_if.source        rsp_ch,
   aros_csr_if.sink          csr_ch,
   input  wire aros_cmd_type cmd,
   output aros_sts_type      sts
);

   localparam int NUM_SHIFTS = (MAX_SHIFTS < READ_LEN) ? MAX_SHIFTS : READ_LEN;
   localparam int PW = $clog2(READ_LEN + 1);
   localparam int AW = $clog2(READ_LEN);
   localparam int KW = (NUM_SHIFTS > 1) ? $clog2(NUM_SHIFTS) : 1;
   localparam int VW = $clog2(READ_LEN) + 1;

   localparam logic [PW-1:0]        LEN_P   = PW'(READ_LEN);
   localparam logic [PW:0]          LEN_R   = (PW + 1)'(READ_LEN);
   localparam logic [KW-1:0]        LAST_K  = KW'(NUM_SHIFTS - 1);
   localparam logic signed [VW-1:0] TOP_VAL = VW'(READ_LEN - 1);

   logic [BASE_W-1:0] mem_ff [READ_LEN];
   logic [BASE_W-1:0] rd_data_ff;
   logic              rd_ok_ff;

   logic [PW-1:0]     pos_ff, pos_in;
   logic [PW-1:0]     cur_pos_ff;
   logic              upd_ff;
   logic [BASE_W-1:0] base_ff;
   logic [CID_W-1:0]  cid_ff;
   logic              last_ff;

   logic [KW-1:0]     k_ff;
   logic [CNT_W-1:0]  cnt_ff [NUM_SHIFTS];
   logic              found_ff;
   logic [KW-1:0]     kfound_ff;
   logic [LIMIT_W-1:0] limit_ff;

   logic signed [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic signed [VW-1:0]    best_val_ff, best_val_in;

   logic                    rsp_valid_ff;
   logic                    rsp_found_ff;
   logic signed [VAL_W-1:0] rsp_value_ff;
   logic signed [IDX_W-1:0] rsp_idx_ff;
   logic signed [VAL_W-1:0] rsp_best_ff;

   logic              accept;
   logic              is_ref;
   logic              pos_in_range;
   logic [PW:0]       r_sum;
   logic              r_ok;
   logic [AW-1:0]     rd_addr;
   logic [CNT_W-1:0]  cnt_cur;
   logic              inc;
   logic [CNT_W-1:0]  cnt_new;
   logic signed [VW-1:0] val_full;
   logic              take_best;

   assign req_ch.ready = cmd.idle;
   assign csr_ch.ready = 1'b1;

   assign accept       = req_ch.valid && req_ch.ready;
   assign is_ref       = (req_ch.cmd == CMD_REF);
   assign pos_in_range = (pos_ff < LEN_P);

   // reference index for the current shift
   assign r_sum   = {1'b0, cur_pos_ff} + (PW + 1)'(k_ff);
   assign r_ok    = (r_sum < LEN_R);
   assign rd_addr = r_ok ? r_sum[AW-1:0] : '0;

   assign cnt_cur = cnt_ff[k_ff];
   assign inc     = upd_ff && rd_ok_ff && (rd_data_ff != base_ff) && (cnt_cur != CNT_MAX);
   assign cnt_new = cnt_cur + CNT_W'(inc);

   assign val_full    = found_ff ? (TOP_VAL - VW'(kfound_ff)) : '1;
   assign take_best   = found_ff && (val_full >= best_val_ff);
   assign best_idx_in = take_best ? IDX_W'({1'b0, cid_ff}) : best_idx_ff;
   assign best_val_in = take_best ? val_full : best_val_ff;

   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         if (is_ref && req_ch.last_base) pos_in = '0;
         else if (pos_in_range)          pos_in = pos_ff + PW'(1);
      end else if (cmd.fin) begin
         pos_in = '0;
      end
   end

   // reference store, no reset: entries are undefined until loaded
   always_ff @(posedge clock) begin
      if (accept && is_ref && pos_in_range) mem_ff[pos_ff[AW-1:0]] <= req_ch.base;
      if (cmd.rd) begin
         rd_data_ff <= mem_ff[rd_addr];
         rd_ok_ff   <= r_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         base_ff    <= req_ch.base;
         cid_ff     <= req_ch.candidate_id;
         last_ff    <= req_ch.last_base;
         cur_pos_ff <= pos_ff;
         upd_ff     <= pos_in_range;
      end
      if (cmd.cmp && !found_ff && (cnt_new <= limit_ff)) kfound_ff <= k_ff;
      if (cmd.fin) begin
         rsp_found_ff <= found_ff;
         rsp_value_ff <= VAL_W'(val_full);
         rsp_idx_ff   <= best_idx_in;
         rsp_best_ff  <= VAL_W'(best_val_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         k_ff         <= '0;
         found_ff     <= 1'b0;
         limit_ff     <= LIMIT_RESET;
         best_idx_ff  <= '1;
         best_val_ff  <= '1;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_SHIFTS; i++) cnt_ff[i] <= '0;
      end else begin
         pos_ff <= pos_in;
         if (csr_ch.valid) limit_ff <= csr_ch.data;

         if (accept) begin
            k_ff     <= '0;
            found_ff <= 1'b0;
            if (is_ref) begin
               best_idx_ff <= '1;
               best_val_ff <= '1;
               for (int i = 0; i < NUM_SHIFTS; i++) cnt_ff[i] <= '0;
            end
         end

         if (cmd.cmp) begin
            cnt_ff[k_ff] <= cnt_new;
            if (cnt_new <= limit_ff) found_ff <= 1'b1;
            if (k_ff != LAST_K) k_ff <= k_ff + KW'(1);
         end

         if (cmd.fin) begin
            best_idx_ff  <= best_idx_in;
            best_val_ff  <= best_val_in;
            rsp_valid_ff <= 1'b1;
            for (int i = 0; i < NUM_SHIFTS; i++) cnt_ff[i] <= '0;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.candidate_found = rsp_found_ff;
   assign rsp_ch.candidate_value = rsp_value_ff;
   assign rsp_ch.best_index      = rsp_idx_ff;
   assign rsp_ch.best_value      = rsp_best_ff;

   always_comb begin
      sts.cand_go    = req_ch.valid && (req_ch.cmd == CMD_CAND);
      sts.last_shift = (k_ff == LAST_K);
      sts.last_item  = last_ff;
      sts.out_free   = !rsp_valid_ff || rsp_ch.ready;
   end

endmodule

`default_nettype wire

@@ rtl/aros_chk.sv @@
// aros_chk: port-level checks on the result channel, bound to the top level
// depends on aros_pkg for field widths
`default_nettype none

module aros_chk import aros_pkg::*; (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire logic                    rsp_found,
   input wire logic signed [VAL_W-1:0] rsp_value,
   input wire logic signed [IDX_W-1:0] rsp_best_index
);

   localparam logic signed [VAL_W-1:0] NONE_VAL = '1;
   localparam logic signed [IDX_W-1:0] NONE_IDX = '1;

   // a stalled item stays offered
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp item dropped while stalled");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // a miss reports no overlap
   a_miss_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_value == NONE_VAL)
      else $error("miss with overlap value");

   // a hit always leaves a best candidate
   a_hit_best: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_best_index != NONE_IDX)
      else $error("hit without best candidate");

endmodule

bind approx_read_overlap_select aros_chk u_aros_chk (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_found      (rsp_ch.candidate_found),
   .rsp_value      (rsp_ch.candidate_value),
   .rsp_best_index (rsp_ch.best_index)
);

`default_nettype wire
